// ===== design/assert_macros.svh =====
// Assertion macros used by the lexer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define MCTL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mctl assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define MCTL_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mctl forbidden condition seen");
`else
`define MCTL_ASSERT(lbl, clk, rst_n, prop)
`define MCTL_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/mctl_pkg.sv =====
// Shared types, codes and constants of the mini C token lexer.
`default_nettype none
package mctl_pkg;

  localparam int unsigned BUFFER_LEN_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [3:0] {
    TT_INT     = 4'd0,
    TT_IDENT   = 4'd1,
    TT_NUMBER  = 4'd2,
    TT_ASSIGN  = 4'd3,
    TT_PLUS    = 4'd4,
    TT_MINUS   = 4'd5,
    TT_IF      = 4'd6,
    TT_LPAREN  = 4'd8,
    TT_RPAREN  = 4'd9,
    TT_SEMI    = 4'd10,
    TT_END     = 4'd11,
    TT_UNKNOWN = 4'd12
  } token_type_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER
  } lex_mode_e;

  typedef enum logic [0:0] {
    B_IDLE,
    B_REPLAY
  } back_state_e;

  typedef enum logic [2:0] {
    OP_START,
    OP_APPEND,
    OP_FLUSH,
    OP_SINGLE,
    OP_END
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    token_type_e ttype;
    logic [7:0]  chr;
  } cmd_t;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;

endpackage
`default_nettype wire

// ===== design/mctl_front.sv =====
// Front end: accepts source bytes, tracks the lexer mode and issues commands.
`default_nettype none
module mctl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     input_byte_i,
  input  logic           end_of_input_i,
  output logic           push_o,
  output mctl_pkg::cmd_t cmd_o,
  input  logic           full_i
);
  import mctl_pkg::*;

  lex_mode_e  mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_a_q, cmd_a_d;
  cmd_t       cmd_b_q, cmd_b_d;

  logic       accept;
  logic       pushed;
  logic       c_ws, c_letter, c_digit;
  logic       idle_valid;
  cmd_t       idle_cmd;
  lex_mode_e  idle_mode;
  token_type_e single_type;
  logic [1:0] new_cnt;
  cmd_t       new_a, new_b;
  lex_mode_e  new_mode;

  always_comb begin
    c_ws     = input_byte_i inside {8'd32, [8'd9:8'd13]};
    c_letter = input_byte_i inside {[8'd65:8'd90], [8'd97:8'd122]};
    c_digit  = input_byte_i inside {[8'd48:8'd57]};
  end

  // What a byte does when no word or number is pending.
  always_comb begin
    case (input_byte_i)
      CH_EQ:     single_type = TT_ASSIGN;
      CH_PLUS:   single_type = TT_PLUS;
      CH_MINUS:  single_type = TT_MINUS;
      CH_LPAREN: single_type = TT_LPAREN;
      CH_RPAREN: single_type = TT_RPAREN;
      CH_SEMI:   single_type = TT_SEMI;
      default:   single_type = TT_UNKNOWN;
    endcase
    idle_cmd.chr   = input_byte_i;
    idle_cmd.ttype = single_type;
    idle_cmd.op    = OP_SINGLE;
    idle_valid     = 1'b1;
    idle_mode      = MODE_IDLE;
    if (c_ws) begin
      idle_valid = 1'b0;
    end else if (c_letter) begin
      idle_cmd.op = OP_START;
      idle_mode   = MODE_WORD;
    end else if (c_digit) begin
      idle_cmd.op = OP_START;
      idle_mode   = MODE_NUMBER;
    end
  end

  // Next mode and the commands that the accepted byte causes.
  always_comb begin
    new_a       = idle_cmd;
    new_b       = idle_cmd;
    new_cnt     = {1'b0, idle_valid};
    new_mode    = idle_mode;
    new_a.op    = OP_FLUSH;
    new_a.ttype = (mode_q == MODE_NUMBER) ? TT_NUMBER : TT_IDENT;
    if (end_of_input_i) begin
      new_b.op    = OP_END;
      new_b.ttype = TT_END;
      new_b.chr   = 8'h00;
      new_mode    = MODE_IDLE;
      if (mode_q == MODE_IDLE) begin
        new_a   = new_b;
        new_cnt = 2'd1;
      end else begin
        new_cnt = 2'd2;
      end
    end else begin
      case (mode_q)
        MODE_WORD, MODE_NUMBER: begin
          if (c_digit || (c_letter && mode_q == MODE_WORD)) begin
            new_a.op  = OP_APPEND;
            new_a.chr = input_byte_i;
            new_cnt   = 2'd1;
            new_mode  = mode_q;
          end else begin
            new_cnt = 2'd1 + {1'b0, idle_valid};
          end
        end
        default: begin
          new_a = idle_cmd;
        end
      endcase
    end
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    cmd_a_d = cmd_a_q;
    cmd_b_d = cmd_b_q;
    if (accept) begin
      mode_d  = new_mode;
      cnt_d   = new_cnt;
      cmd_a_d = new_a;
      cmd_b_d = new_b;
    end else if (pushed) begin
      cnt_d   = cnt_q - 2'd1;
      cmd_a_d = cmd_b_q;
    end
  end

  always_comb begin
    in_stall_o = (cnt_q != 2'd0);
    accept     = in_valid_i && !in_stall_o;
    push_o     = (cnt_q != 2'd0);
    pushed     = push_o && !full_i;
    cmd_o      = cmd_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_a_q <= cmd_a_d;
    cmd_b_q <= cmd_b_d;
  end

endmodule
`default_nettype wire

// ===== design/mctl_queue.sv =====
// Command queue between the front end and the token emitter.
`default_nettype none
module mctl_queue #(
  parameter int unsigned DEPTH = mctl_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mctl_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output mctl_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import mctl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  always_comb begin
    full_o  = (count_q == CW'(DEPTH));
    empty_o = (count_q == '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    cmd_o   = slots_q[rd_q];
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/mctl_back.sv =====
// Back end: holds the token text, classifies words and emits character beats.
`default_nettype none
`include "assert_macros.svh"
module mctl_back #(
  parameter int unsigned BUFFER_LEN = mctl_pkg::BUFFER_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  mctl_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [3:0]     token_type_o,
  output logic [7:0]     text_char_o,
  output logic [5:0]     char_index_o,
  output logic           last_of_token_o
);
  import mctl_pkg::*;

  localparam int unsigned STORE_DEPTH = BUFFER_LEN - 1;
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = $clog2(BUFFER_LEN);

  back_state_e   state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  token_type_e   tok_q, tok_d;
  logic          m0_q, m0_d, m1n_q, m1n_d, m1f_q, m1f_d, m2t_q, m2t_d;

  logic [7:0]    store_q [STORE_DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic          out_valid_q;
  token_type_e   out_type_q, out_type_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [5:0]    out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;
  logic          load_out;

  logic          slot_free;
  logic [LW:0]   idx_inc;
  logic          last;
  logic          room;
  token_type_e   word_type;

  always_comb begin
    slot_free = !out_valid_q || !out_stall_i;
    idx_inc   = (LW + 1)'(idx_q) + (LW + 1)'(1);
    last      = (idx_inc == (LW + 1)'(len_q));
    room      = (len_q < LW'(STORE_DEPTH));
    if (q_cmd_i.ttype == TT_NUMBER) begin
      word_type = TT_NUMBER;
    end else if (len_q == LW'(3) && m0_q && m1n_q && m2t_q) begin
      word_type = TT_INT;
    end else if (len_q == LW'(2) && m0_q && m1f_q) begin
      word_type = TT_IF;
    end else begin
      word_type = TT_IDENT;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i && q_cmd_i.op == OP_FLUSH) begin
          state_d = B_REPLAY;
        end
      end
      B_REPLAY: begin
        if (slot_free && last) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    q_pop_o    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = len_q[AW-1:0];
    rd_addr    = idx_q;
    load_out   = 1'b0;
    len_d      = len_q;
    idx_d      = idx_q;
    tok_d      = tok_q;
    m0_d       = m0_q;
    m1n_d      = m1n_q;
    m1f_d      = m1f_q;
    m2t_d      = m2t_q;
    out_type_d = q_cmd_i.ttype;
    out_char_d = q_cmd_i.chr;
    out_idx_d  = 6'd0;
    out_last_d = 1'b1;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.op)
            OP_START: begin
              q_pop_o = 1'b1;
              wr_en   = 1'b1;
              wr_addr = '0;
              len_d   = LW'(1);
              m0_d    = (q_cmd_i.chr == CH_I);
              m1n_d   = 1'b0;
              m1f_d   = 1'b0;
              m2t_d   = 1'b0;
            end
            OP_APPEND: begin
              q_pop_o = 1'b1;
              if (room) begin
                wr_en = 1'b1;
                len_d = len_q + LW'(1);
                if (len_q == LW'(1)) begin
                  m1n_d = (q_cmd_i.chr == CH_N);
                  m1f_d = (q_cmd_i.chr == CH_F);
                end
                if (len_q == LW'(2)) begin
                  m2t_d = (q_cmd_i.chr == CH_T);
                end
              end
            end
            OP_FLUSH: begin
              // Start the replay with a read of the first character.
              q_pop_o = 1'b1;
              tok_d   = word_type;
              idx_d   = '0;
              rd_addr = '0;
            end
            OP_SINGLE, OP_END: begin
              if (slot_free) begin
                q_pop_o  = 1'b1;
                load_out = 1'b1;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      B_REPLAY: begin
        out_type_d = tok_q;
        out_char_d = rd_data_q;
        out_idx_d  = 6'(idx_q);
        out_last_d = last;
        if (slot_free) begin
          load_out = 1'b1;
          if (!last) begin
            idx_d   = idx_inc[AW-1:0];
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    m0_q  <= m0_d;
    m1n_q <= m1n_d;
    m1f_q <= m1f_d;
    m2t_q <= m2t_d;
    if (load_out) begin
      out_type_q <= out_type_d;
      out_char_q <= out_char_d;
      out_idx_q  <= out_idx_d;
      out_last_q <= out_last_d;
    end
  end

  // Text store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= q_cmd_i.chr;
    end
    rd_data_q <= store_q[rd_addr];
  end

  always_comb begin
    out_valid_o     = out_valid_q;
    token_type_o    = out_type_q;
    text_char_o     = out_char_q;
    char_index_o    = out_idx_q;
    last_of_token_o = out_last_q;
  end

  `MCTL_ASSERT(a_replay_idx_range, clk_i, rst_ni, (state_q == B_REPLAY) |-> (LW'(idx_q) < len_q))
  `MCTL_NEVER(a_no_pop_in_replay, clk_i, rst_ni, (state_q == B_REPLAY) && q_pop_o)
  `MCTL_NEVER(a_len_in_range, clk_i, rst_ni, len_q > LW'(STORE_DEPTH))
  `MCTL_ASSERT(a_replay_has_text, clk_i, rst_ni, $rose(state_q == B_REPLAY) |-> (len_q != '0))

endmodule
`default_nettype wire

// ===== design/mini_c_token_lexer_unit.sv =====
// Top level of the mini C token lexer: front end, command queue, emitter.
//
//   Channel | Direction | Handshake                | Payload
//   input   | in        | in_valid_i / in_stall_o  | input_byte_i, end_of_input_i
//   result  | out       | out_valid_o / out_stall_i| token_type_o, text_char_o,
//           |           |                          | char_index_o, last_of_token_o
//
// An item is taken and then held off while its queue commands are pushed, one per cycle
// while the queue has room: one command per item, none for whitespace, plus a flush when
// the item ends a word or number. The emitter stores each word or number character; for
// a finished token it first reads the first character, then replays the token at one beat
// per cycle unless the result is stalled.
// Reset is asynchronous and clears only control state; a result stall holds the emitter.
`default_nettype none
module mini_c_token_lexer_unit #(
  parameter int unsigned BUFFER_LEN  = mctl_pkg::BUFFER_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH = mctl_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] input_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_type_o,
  output logic [7:0] text_char_o,
  output logic [5:0] char_index_o,
  output logic       last_of_token_o
);
  import mctl_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  mctl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .input_byte_i   (input_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full)
  );

  mctl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  mctl_back #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (empty),
    .q_cmd_i         (pop_cmd),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_type_o    (token_type_o),
    .text_char_o     (text_char_o),
    .char_index_o    (char_index_o),
    .last_of_token_o (last_of_token_o)
  );

endmodule
`default_nettype wire
